/* hdl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types, widths and constants of the rotation matrix to quaternion unit
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int ROT_FRAC_BITS = 14;
  localparam int ENTRY_W       = 16;
  localparam int POS_W         = 32;
  localparam int NUM_W         = ENTRY_W + 1;
  localparam int QUAT_W        = 16;
  localparam int NUM_LANES     = 3;
  localparam int FIFO_DEPTH    = 4;

  typedef enum logic [1:0] {
    LEAD_X = 2'd0,
    LEAD_Y = 2'd1,
    LEAD_Z = 2'd2,
    LEAD_W = 2'd3
  } lead_t;

  typedef struct packed {
    logic [POS_W-1:0]                 pos_x;
    logic [POS_W-1:0]                 pos_y;
    logic [POS_W-1:0]                 pos_z;
    logic                             degenerate;
    lead_t                            lead;
    logic [NUM_LANES-1:0][NUM_W-1:0]  num;
  } rmq_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rmq_fifo_stat_t;

  // width of the signed square-root argument
  function automatic int rmq_a_w(input int f);
    return ((f > ENTRY_W + 1) ? f : ENTRY_W + 1) + 3;
  endfunction

endpackage

/* hdl/rmq_if.sv */
// ----------------------------------------------------------------------------
// rmq_if
// valid/ready channels for transform items and pose result items
// ----------------------------------------------------------------------------
interface rmq_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] rot_00;
  logic [15:0] rot_01;
  logic [15:0] rot_02;
  logic [15:0] rot_10;
  logic [15:0] rot_11;
  logic [15:0] rot_12;
  logic [15:0] rot_20;
  logic [15:0] rot_21;
  logic [15:0] rot_22;
  logic [31:0] trans_x;
  logic [31:0] trans_y;
  logic [31:0] trans_z;

  modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                  rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, input ready);
  modport sink (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                rot_20, rot_21, rot_22, trans_x, trans_y, trans_z, output ready);
endinterface

interface rmq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [15:0] quat_x;
  logic [15:0] quat_y;
  logic [15:0] quat_z;
  logic [15:0] quat_w;
  logic        degenerate;

  modport source (output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z,
                  quat_w, degenerate, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z,
                quat_w, degenerate, output ready);
endinterface

/* hdl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// classifies a transform: leading component, square-root argument, numerators
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int F  = rmq_pkg::ROT_FRAC_BITS,
  parameter int AW = rmq_pkg::rmq_a_w(F)
) (
  rmq_in_if.sink                in_ch,
  output rmq_pkg::rmq_item_t    item,
  output logic signed [AW-1:0]  arg
);

  localparam int NW = rmq_pkg::NUM_W;
  localparam logic signed [AW-1:0] ONE = {{(AW-F-1){1'b0}}, 1'b1, {F{1'b0}}};

  logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [AW-1:0] e00, e11, e22;
  logic signed [17:0] trace;
  rmq_pkg::lead_t lead;

  assign r00 = signed'(in_ch.rot_00);
  assign r01 = signed'(in_ch.rot_01);
  assign r02 = signed'(in_ch.rot_02);
  assign r10 = signed'(in_ch.rot_10);
  assign r11 = signed'(in_ch.rot_11);
  assign r12 = signed'(in_ch.rot_12);
  assign r20 = signed'(in_ch.rot_20);
  assign r21 = signed'(in_ch.rot_21);
  assign r22 = signed'(in_ch.rot_22);

  assign e00 = AW'(r00);
  assign e11 = AW'(r11);
  assign e22 = AW'(r22);
  assign trace = 18'(r00) + 18'(r11) + 18'(r22);

  always_comb begin
    if (trace > 18'sd0) begin
      lead = rmq_pkg::LEAD_W;
    end else if (r00 < r11) begin
      lead = (r11 < r22) ? rmq_pkg::LEAD_Z : rmq_pkg::LEAD_Y;
    end else begin
      lead = (r00 < r22) ? rmq_pkg::LEAD_Z : rmq_pkg::LEAD_X;
    end
  end

  always_comb begin
    item.pos_x = in_ch.trans_x;
    item.pos_y = in_ch.trans_y;
    item.pos_z = in_ch.trans_z;
    item.lead  = lead;
    unique case (lead)
      rmq_pkg::LEAD_W: begin
        arg         = AW'(trace) + ONE;
        item.num[0] = NW'(r21) - NW'(r12);
        item.num[1] = NW'(r02) - NW'(r20);
        item.num[2] = NW'(r10) - NW'(r01);
      end
      rmq_pkg::LEAD_X: begin
        arg         = e00 - e11 - e22 + ONE;
        item.num[0] = NW'(r10) + NW'(r01);
        item.num[1] = NW'(r20) + NW'(r02);
        item.num[2] = NW'(r21) - NW'(r12);
      end
      rmq_pkg::LEAD_Y: begin
        arg         = e11 - e22 - e00 + ONE;
        item.num[0] = NW'(r21) + NW'(r12);
        item.num[1] = NW'(r01) + NW'(r10);
        item.num[2] = NW'(r02) - NW'(r20);
      end
      default: begin
        arg         = e22 - e00 - e11 + ONE;
        item.num[0] = NW'(r02) + NW'(r20);
        item.num[1] = NW'(r12) + NW'(r21);
        item.num[2] = NW'(r10) - NW'(r01);
      end
    endcase
    item.degenerate = (lead != rmq_pkg::LEAD_W) && (arg <= AW'(0));
  end

endmodule

/* hdl/rmq_fifo.sv */
// ----------------------------------------------------------------------------
// rmq_fifo
// short register queue between the classifier and the arithmetic pipeline
// ----------------------------------------------------------------------------
module rmq_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = rmq_pkg::FIFO_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  logic [W-1:0]            wr_data,
  input  logic                    pop,
  output logic [W-1:0]            rd_data,
  output rmq_pkg::rmq_fifo_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

/* hdl/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back
// pipelined square root, three pipelined rounding dividers, saturation, output
// ----------------------------------------------------------------------------
module rmq_back #(
  parameter int F  = rmq_pkg::ROT_FRAC_BITS,
  parameter int AW = rmq_pkg::rmq_a_w(F)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_vld,
  input  rmq_pkg::rmq_item_t    head_item,
  input  logic signed [AW-1:0]  head_arg,
  output logic                  pop,
  rmq_out_if.source             out_ch
);

  localparam int XW  = AW - 1 + F;
  localparam int SQW = (XW + 1) / 2;
  localparam int NW  = rmq_pkg::NUM_W;
  localparam int DW  = NW + F + 1;
  localparam int NL  = rmq_pkg::NUM_LANES;

  logic en;

  // square root stages
  logic                 sq_vld_r  [0:SQW];
  logic [SQW+1:0]       sq_rem_r  [0:SQW];
  logic [SQW-1:0]       sq_root_r [0:SQW];
  logic [2*SQW-1:0]     sq_x_r    [0:SQW];
  rmq_pkg::rmq_item_t   sq_item_r [0:SQW];

  // divider stages
  logic                 dv_vld_r  [0:DW];
  logic [SQW:0]         dv_den_r  [0:DW];
  logic [SQW-1:0]       dv_lead_r [0:DW];
  logic [NL-1:0]        dv_neg_r  [0:DW];
  logic [SQW:0]         dv_rem_r  [0:DW][NL];
  logic [DW-1:0]        dv_dd_r   [0:DW][NL];
  rmq_pkg::rmq_item_t   dv_item_r [0:DW];

  logic        out_vld_r;
  logic [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic [15:0] qx_r, qy_r, qz_r, qw_r;
  logic        degen_r;

  assign en  = !out_vld_r || out_ch.ready;
  assign pop = en && head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= head_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_item_r[0] <= head_item;
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      sq_x_r[0]    <= (2*SQW)'({head_arg[AW-2:0], {F{1'b0}}});
    end
  end

  for (genvar s = 1; s <= SQW; s++) begin : g_sq
    logic [SQW+1:0] t, trial;
    logic           ge;
    assign t     = {sq_rem_r[s-1][SQW-1:0], sq_x_r[s-1][2*SQW-1 -: 2]};
    assign trial = {sq_root_r[s-1], 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[s] <= 1'b0;
      end else if (en) begin
        sq_vld_r[s] <= sq_vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem_r[s]  <= ge ? (t - trial) : t;
        sq_root_r[s] <= {sq_root_r[s-1][SQW-2:0], ge};
        sq_x_r[s]    <= sq_x_r[s-1] << 2;
        sq_item_r[s] <= sq_item_r[s-1];
      end
    end
  end

  // divider setup from the root
  logic [SQW-1:0] root;
  logic [SQW:0]   root_inc;
  assign root     = sq_root_r[SQW];
  assign root_inc = {1'b0, root} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[SQW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_item_r[0] <= sq_item_r[SQW];
      dv_den_r[0]  <= {root, 1'b0};
      dv_lead_r[0] <= root_inc[SQW:1];
    end
  end

  for (genvar l = 0; l < NL; l++) begin : g_setup
    logic [NW-1:0] n, mag;
    assign n   = sq_item_r[SQW].num[l];
    assign mag = n[NW-1] ? (~n + 1'b1) : n;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_neg_r[0][l] <= n[NW-1];
        dv_rem_r[0][l] <= '0;
        dv_dd_r[0][l]  <= DW'({mag, {F{1'b0}}}) + DW'(root);
      end
    end
  end

  for (genvar s = 1; s <= DW; s++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s] <= 1'b0;
      end else if (en) begin
        dv_vld_r[s] <= dv_vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_item_r[s] <= dv_item_r[s-1];
        dv_den_r[s]  <= dv_den_r[s-1];
        dv_lead_r[s] <= dv_lead_r[s-1];
        dv_neg_r[s]  <= dv_neg_r[s-1];
      end
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [SQW+1:0] t, d, diff;
      logic           ge;
      assign t    = {dv_rem_r[s-1][l], dv_dd_r[s-1][l][DW-1]};
      assign d    = {1'b0, dv_den_r[s-1]};
      assign ge   = (t >= d);
      assign diff = ge ? (t - d) : t;
      always_ff @(posedge clk) begin
        if (en) begin
          dv_rem_r[s][l] <= diff[SQW:0];
          dv_dd_r[s][l]  <= {dv_dd_r[s-1][l][DW-2:0], ge};
        end
      end
    end
  end

  // sign, saturation and component placement
  logic [15:0]     qv [NL];
  logic [15:0]     lead_v;
  logic [SQW+15:0] lead_ext;
  assign lead_ext = (SQW+16)'(dv_lead_r[DW]);
  assign lead_v   = (lead_ext > (SQW+16)'(32767)) ? 16'h7fff : lead_ext[15:0];

  for (genvar l = 0; l < NL; l++) begin : g_sat
    logic [DW-1:0] q;
    assign q = dv_dd_r[DW][l];
    always_comb begin
      if (dv_neg_r[DW][l]) begin
        qv[l] = (q > DW'(32768)) ? 16'h8000 : (~q[15:0] + 1'b1);
      end else begin
        qv[l] = (q > DW'(32767)) ? 16'h7fff : q[15:0];
      end
    end
  end

  logic [15:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  always_comb begin
    unique case (dv_item_r[DW].lead)
      rmq_pkg::LEAD_W: begin
        qx_nxt = qv[0]; qy_nxt = qv[1]; qz_nxt = qv[2]; qw_nxt = lead_v;
      end
      rmq_pkg::LEAD_X: begin
        qx_nxt = lead_v; qy_nxt = qv[0]; qz_nxt = qv[1]; qw_nxt = qv[2];
      end
      rmq_pkg::LEAD_Y: begin
        qx_nxt = qv[1]; qy_nxt = lead_v; qz_nxt = qv[0]; qw_nxt = qv[2];
      end
      default: begin
        qx_nxt = qv[0]; qy_nxt = qv[1]; qz_nxt = lead_v; qw_nxt = qv[2];
      end
    endcase
    if (dv_item_r[DW].degenerate) begin
      qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x_r <= dv_item_r[DW].pos_x;
      pos_y_r <= dv_item_r[DW].pos_y;
      pos_z_r <= dv_item_r[DW].pos_z;
      degen_r <= dv_item_r[DW].degenerate;
      qx_r    <= qx_nxt;
      qy_r    <= qy_nxt;
      qz_r    <= qz_nxt;
      qw_r    <= qw_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.pos_x      = pos_x_r;
  assign out_ch.pos_y      = pos_y_r;
  assign out_ch.pos_z      = pos_z_r;
  assign out_ch.quat_x     = qx_r;
  assign out_ch.quat_y     = qy_r;
  assign out_ch.quat_z     = qz_r;
  assign out_ch.quat_w     = qw_r;
  assign out_ch.degenerate = degen_r;

endmodule

/* hdl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// rigid transform to position and unit quaternion, one item per cycle unless out_ch stalls
//
// in_ch carries one 3x4 transform per item: nine signed rotation entries with
// F fraction bits and a Q16.16 translation. out_ch returns one result item per
// input item, in order: the translation as position, the quaternion x, y, z, w
// saturated to 16 bits, and a degenerate flag that zeroes the quaternion.
// An accepted item is classified and written to a four-entry queue; the back
// end pulls it through a square-root pipeline of one result bit per stage and
// three restoring dividers of one quotient bit per stage.
// At F = 14 the back end has SQW = 17 root stages and DW = 32 quotient stages;
// throughput is one item per cycle while the receiver does not stall.
// A stalled receiver holds the output register and freezes the pipeline; the
// queue keeps taking items until it is full, then in_ch.ready drops.
// Reset clears the queue and all stage valid bits; no item is in flight after.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
  parameter int ROT_FRAC_BITS = rmq_pkg::ROT_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  rmq_in_if.sink     in_ch,
  rmq_out_if.source  out_ch
);

  localparam int AW = rmq_pkg::rmq_a_w(ROT_FRAC_BITS);
  localparam int IW = $bits(rmq_pkg::rmq_item_t);
  localparam int QW = IW + AW;

  rmq_pkg::rmq_item_t      fr_item, hd_item;
  logic signed [AW-1:0]    fr_arg, hd_arg;
  logic [QW-1:0]           hd_data;
  logic                    push, pop;
  rmq_pkg::rmq_fifo_stat_t fifo_stat;

  rmq_front #(.F(ROT_FRAC_BITS), .AW(AW)) u_front (
    .in_ch (in_ch),
    .item  (fr_item),
    .arg   (fr_arg)
  );

  assign in_ch.ready = !fifo_stat.full;
  assign push        = in_ch.valid && !fifo_stat.full;

  rmq_fifo #(.W(QW), .DEPTH(rmq_pkg::FIFO_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_data ({fr_item, fr_arg}),
    .pop     (pop),
    .rd_data (hd_data),
    .stat    (fifo_stat)
  );

  assign hd_item = hd_data[QW-1:AW];
  assign hd_arg  = hd_data[AW-1:0];

  rmq_back #(.F(ROT_FRAC_BITS), .AW(AW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_vld  (!fifo_stat.empty),
    .head_item (hd_item),
    .head_arg  (hd_arg),
    .pop       (pop),
    .out_ch    (out_ch)
  );

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |-> (out_ch.quat_x == '0) &&
      (out_ch.quat_y == '0) && (out_ch.quat_z == '0) && (out_ch.quat_w == '0))
    else $error("degenerate item with nonzero quaternion");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_stat.full |-> !in_ch.ready && !push)
    else $error("item taken while queue full");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !fifo_stat.empty)
    else $error("accepted item missing from queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

endmodule

/* dv/rotation_matrix_to_quaternion_unit_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_checker
// watches the transform and pose channels, predicts each pose from the
// accepted transform and compares it field by field in arrival order
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_checker (
  input  logic      clk,
  input  logic      rst_n,
  rmq_in_if.sink    in_mon,
  rmq_out_if.sink   out_mon,
  output int        n_errors,
  output int        n_pending,
  output int        n_poses,
  output int        n_degenerate
);

  localparam int F = rmq_pkg::ROT_FRAC_BITS;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [15:0] qx;
    logic [15:0] qy;
    logic [15:0] qz;
    logic [15:0] qw;
    logic        degenerate;
  } pose_t;

  pose_t pose_q[$];

  function automatic longint root_floor(input longint x);
    longint r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= x)
        r = r + (longint'(1) << b);
    end
    return r;
  endfunction

  function automatic logic [15:0] clip16(input longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint round_div(input longint n, input longint s);
    longint num, den, mag, q;
    num = n * (longint'(1) << F);
    den = 2 * s;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic pose_t predict_pose(input logic [8:0][15:0] e,
                                         input logic [31:0] tx, ty, tz);
    longint r[3][3];
    longint q[4];
    longint one, a, s, tr;
    int i, j, k;
    pose_t p;
    one = longint'(1) << F;
    for (int m = 0; m < 4; m++) q[m] = 0;
    for (int m = 0; m < 9; m++) r[m / 3][m % 3] = longint'($signed(e[m]));
    p.degenerate = 1'b0;
    tr = r[0][0] + r[1][1] + r[2][2];
    if (tr > 0) begin
      s = root_floor((tr + one) << F);
      q[3] = (s + 1) >>> 1;
      q[0] = round_div(r[2][1] - r[1][2], s);
      q[1] = round_div(r[0][2] - r[2][0], s);
      q[2] = round_div(r[1][0] - r[0][1], s);
    end else begin
      i = (r[0][0] < r[1][1]) ? ((r[1][1] < r[2][2]) ? 2 : 1)
                              : ((r[0][0] < r[2][2]) ? 2 : 0);
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      a = r[i][i] - r[j][j] - r[k][k] + one;
      if (a <= 0) begin
        p.degenerate = 1'b1;
      end else begin
        s = root_floor(a << F);
        q[i] = (s + 1) >>> 1;
        q[3] = round_div(r[k][j] - r[j][k], s);
        q[j] = round_div(r[j][i] + r[i][j], s);
        q[k] = round_div(r[k][i] + r[i][k], s);
      end
    end
    p.pos_x = tx;
    p.pos_y = ty;
    p.pos_z = tz;
    p.qx = clip16(q[0]);
    p.qy = clip16(q[1]);
    p.qz = clip16(q[2]);
    p.qw = clip16(q[3]);
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  initial begin
    n_errors = 0;
    n_pending = 0;
    n_poses = 0;
    n_degenerate = 0;
  end

  always @(posedge clk) begin
    pose_t exp_p;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        pose_q.insert(pose_q.size(),
                      predict_pose({in_mon.rot_22, in_mon.rot_21, in_mon.rot_20,
                                    in_mon.rot_12, in_mon.rot_11, in_mon.rot_10,
                                    in_mon.rot_02, in_mon.rot_01, in_mon.rot_00},
                                   in_mon.trans_x, in_mon.trans_y, in_mon.trans_z));
      if (out_mon.valid && out_mon.ready) begin
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected pose", 0, 0);
        end else begin
          exp_p = pose_q.pop_front();
          n_poses++;
          if (exp_p.degenerate) n_degenerate++;
          if (out_mon.pos_x !== exp_p.pos_x) report_mismatch("pos_x", out_mon.pos_x, exp_p.pos_x);
          if (out_mon.pos_y !== exp_p.pos_y) report_mismatch("pos_y", out_mon.pos_y, exp_p.pos_y);
          if (out_mon.pos_z !== exp_p.pos_z) report_mismatch("pos_z", out_mon.pos_z, exp_p.pos_z);
          if (out_mon.quat_x !== exp_p.qx) report_mismatch("quat_x", out_mon.quat_x, exp_p.qx);
          if (out_mon.quat_y !== exp_p.qy) report_mismatch("quat_y", out_mon.quat_y, exp_p.qy);
          if (out_mon.quat_z !== exp_p.qz) report_mismatch("quat_z", out_mon.quat_z, exp_p.qz);
          if (out_mon.quat_w !== exp_p.qw) report_mismatch("quat_w", out_mon.quat_w, exp_p.qw);
          if (out_mon.degenerate !== exp_p.degenerate)
            report_mismatch("degenerate", out_mon.degenerate, exp_p.degenerate);
        end
      end
    end
    n_pending <= pose_q.size();
  end
endmodule

/* dv/rotation_matrix_to_quaternion_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// drives directed and random transforms with random gaps and result stalls;
// the checker predicts every pose and the top gives the verdict
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;
  localparam int N_RANDOM = 1250;
  localparam int LATENCY  = 52;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   n_errors, n_pending, n_poses, n_degenerate;
  int   n_sent = 0;
  longint cycle_cnt = 0;

  rmq_in_if  in_ch ();
  rmq_out_if out_ch ();

  rotation_matrix_to_quaternion_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  rotation_matrix_to_quaternion_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .n_errors(n_errors), .n_pending(n_pending), .n_poses(n_poses),
    .n_degenerate(n_degenerate)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side stalls
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (cycle_cnt % 4000 < 600) gap = 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  task automatic send_item(input logic [8:0][15:0] e, input logic [31:0] tx, ty, tz);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (n_sent % 300 < 60) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rot_00  <= e[0];
    in_ch.rot_01  <= e[1];
    in_ch.rot_02  <= e[2];
    in_ch.rot_10  <= e[3];
    in_ch.rot_11  <= e[4];
    in_ch.rot_12  <= e[5];
    in_ch.rot_20  <= e[6];
    in_ch.rot_21  <= e[7];
    in_ch.rot_22  <= e[8];
    in_ch.trans_x <= tx;
    in_ch.trans_y <= ty;
    in_ch.trans_z <= tz;
    @(posedge clk iff in_ch.ready);
    n_sent++;
  endtask

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'h8000;
      2: return 16'h7fff;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // rotation about one axis with optional sign flips, entries near unit scale
  task automatic send_rotation();
    logic [8:0][15:0] e;
    int c, s, ax;
    c = $urandom_range(0, 32768) - 16384;
    s = $urandom_range(0, 32768) - 16384;
    ax = $urandom_range(0, 2);
    e = '0;
    e[ax * 4] = 16'sd16384;
    case (ax)
      0: begin e[4] = 16'(c); e[5] = 16'(-s); e[7] = 16'(s); e[8] = 16'(c); end
      1: begin e[0] = 16'(c); e[2] = 16'(s); e[6] = 16'(-s); e[8] = 16'(c); end
      default: begin e[0] = 16'(c); e[1] = 16'(-s); e[3] = 16'(s); e[4] = 16'(c); end
    endcase
    if ($urandom_range(0, 3) == 0) e[ax * 4] = -16'sd16384;
    for (int m = 0; m < 9; m++)
      if ($urandom_range(0, 9) == 0) e[m] = e[m] + 16'($urandom_range(0, 63)) - 16'd32;
    send_item(e, $urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [8:0][15:0] e;
    in_ch.valid = 1'b0;
    {in_ch.rot_00, in_ch.rot_01, in_ch.rot_02, in_ch.rot_10, in_ch.rot_11,
     in_ch.rot_12, in_ch.rot_20, in_ch.rot_21, in_ch.rot_22} = '0;
    {in_ch.trans_x, in_ch.trans_y, in_ch.trans_z} = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity, trace case
    send_item({16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384},
              32'h7fffffff, 32'h80000000, 32'h0);
    // half turns: x, y, z lead
    send_item({-16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384},
              32'h1, 32'hffffffff, 32'h12345678);
    send_item({-16'sd16384, 16'd0, 16'd0, 16'd0, 16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384},
              '0, '0, '0);
    send_item({16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384},
              '0, '0, '0);
    // all zero: tie to x lead, argument exactly one
    send_item('0, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    // ties on the diagonal
    send_item({16'sd100, 16'd5, 16'd7, 16'd3, -16'sd200, 16'd9, 16'd11, 16'd13, -16'sd200},
              '0, '0, '0);
    send_item({-16'sd300, 16'd5, 16'd7, 16'd3, -16'sd300, 16'd9, 16'd11, 16'd13, -16'sd300},
              '0, '0, '0);
    // diagonal all most negative: x lead by tie, positive argument
    send_item({16'h8000, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'h8000},
              32'hdeadbeef, '0, '0);
    // all most negative, all most positive
    send_item({9{16'h8000}}, '0, '0, '0);
    send_item({9{16'h7fff}}, '0, '0, '0);
    // extreme entries of both signs: w lead, then x lead
    send_item({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
               16'h8000}, '0, '0, '0);
    send_item({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
               16'h4001}, '0, '0, '0);

    // let the pipe drain fully once before random traffic
    in_ch.valid <= 1'b0;
    @(posedge clk iff n_pending == 0);

    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 2) != 0) begin
        send_rotation();
      end else begin
        for (int m = 0; m < 9; m++) e[m] = rand_entry();
        send_item(e, $urandom, $urandom, $urandom);
      end
      if (n == N_RANDOM / 2) begin
        in_ch.valid <= 1'b0;
        @(posedge clk iff n_pending == 0);
      end
    end
    in_ch.valid <= 1'b0;

    @(posedge clk iff n_pending == 0);
    repeat (LATENCY * 2) @(posedge clk);
    $display("sent %0d transforms, checked %0d poses, %0d of them degenerate",
             n_sent, n_poses, n_degenerate);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
